### rtl/mhbt_pkg.sv
// mhbt_pkg: shared types and constants for the modulo hash bucket table
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package mhbt_pkg;

  localparam int KEY_W             = 31;
  localparam int CFG_W             = 5;
  localparam int NUM_BUCKETS_DEF   = 16;
  localparam int SLOTS_DEF         = 8;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(7);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

endpackage

### rtl/mhbt_mod_unit.sv
// mhbt_mod_unit: restoring remainder unit, one key bit per cycle
// depends on mhbt_pkg
`timescale 1ns / 1ps

module mhbt_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mhbt_pkg::KEY_W-1:0]   dividend,
  input  logic [mhbt_pkg::CFG_W-1:0]   divisor,
  output logic                         busy,
  output logic                         done,
  output logic [mhbt_pkg::CFG_W-1:0]   rem
);
  import mhbt_pkg::*;

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic [KEY_W-1:0] dvd_r, dvd_nxt;
  logic [CFG_W-1:0] div_r, div_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CFG_W:0]   trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[KEY_W-1]};
    if (start && !busy_r) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(KEY_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CFG_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = CFG_W'(trial);
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("remainder unit flags done while still busy");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CNT_W'(1)) |=> (done_r && !busy_r))
    else $error("remainder unit missed its final step");
`endif

endmodule

### rtl/mhbt_bucket_ram.sv
// mhbt_bucket_ram: one row per bucket holding slot keys and slot valid bits
// depends on mhbt_pkg; rows never written read back as empty
`timescale 1ns / 1ps

module mhbt_bucket_ram #(
  parameter int NUM_BUCKETS      = mhbt_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = mhbt_pkg::SLOTS_DEF,
  parameter int AW               = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        rd_en,
  input  logic                                        wr_en,
  input  logic [AW-1:0]                               addr,
  input  logic [SLOTS_PER_BUCKET*mhbt_pkg::KEY_W-1:0] wr_keys,
  input  logic [SLOTS_PER_BUCKET-1:0]                 wr_vld,
  output logic [SLOTS_PER_BUCKET*mhbt_pkg::KEY_W-1:0] rd_keys,
  output logic [SLOTS_PER_BUCKET-1:0]                 rd_vld
);
  import mhbt_pkg::*;

  localparam int ROW_W = SLOTS_PER_BUCKET * KEY_W;

  logic [ROW_W-1:0]            keys_mem [NUM_BUCKETS];
  logic [SLOTS_PER_BUCKET-1:0] vld_mem  [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0]      row_init_r;
  logic [ROW_W-1:0]            rd_keys_r;
  logic [SLOTS_PER_BUCKET-1:0] rd_vld_r;
  logic                        rd_init_r;

  // memory arrays
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_mem[addr] <= wr_keys;
      vld_mem[addr]  <= wr_vld;
    end
    if (rd_en) begin
      rd_keys_r <= keys_mem[addr];
      rd_vld_r  <= vld_mem[addr];
    end
  end

  // per-row written flags, cleared at reset so the table starts empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
      rd_init_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_init_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_init_r <= row_init_r[addr];
      end
    end
  end

  assign rd_keys = rd_keys_r;
  assign rd_vld  = rd_init_r ? rd_vld_r : '0;

endmodule

### rtl/modulo_hash_bucket_table.sv
// modulo_hash_bucket_table: hash table of keys, bucket = key mod bucket_count
// a result is registered after 31 remainder steps, one row read and one update
// and write-back; in_stall holds off a new item until the last one is through,
// since the bit-serial remainder unit and the single ram port serve one at a time
// reset: synchronous, clears row flags so the table is empty, bucket_count = 7
// depends on mhbt_pkg, mhbt_mod_unit, mhbt_bucket_ram
`timescale 1ns / 1ps

module modulo_hash_bucket_table #(
  parameter int NUM_BUCKETS      = mhbt_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = mhbt_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mhbt_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mhbt_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mhbt_pkg::CFG_W-1:0]   cfg_data
);
  import mhbt_pkg::*;

  localparam int AW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOTS = SLOTS_PER_BUCKET;
  localparam int ROW_W = SLOTS * KEY_W;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] bucket_count_r;
  logic [CFG_W-1:0] active;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [AW-1:0]    bucket_r;
  out_item_t        out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             div_start, div_busy, div_done;
  logic [CFG_W-1:0] div_rem;

  logic             mem_rd_en, mem_wr_en;
  logic [AW-1:0]    mem_addr;
  logic [ROW_W-1:0] rd_keys, wr_keys;
  logic [SLOTS-1:0] rd_vld, wr_vld;

  logic [SLOTS-1:0] hit, free_slots, first_free;
  logic             placed, go, in_xfer;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      bucket_count_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // zero maps to one bucket, large counts saturate
  always_comb begin
    if (bucket_count_r == '0) begin
      active = CFG_W'(1);
    end else if (int'(bucket_count_r) > NUM_BUCKETS) begin
      active = CFG_W'(NUM_BUCKETS);
    end else begin
      active = bucket_count_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign div_start = in_xfer;
  assign go        = !(out_valid_r && out_stall);

  mhbt_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.key),
    .divisor  (active),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  mhbt_bucket_ram #(
    .NUM_BUCKETS      (NUM_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .AW               (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .wr_en   (mem_wr_en),
    .addr    (mem_addr),
    .wr_keys (wr_keys),
    .wr_vld  (wr_vld),
    .rd_keys (rd_keys),
    .rd_vld  (rd_vld)
  );

  // slot compare and lowest free slot
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit[s] = rd_vld[s] && (rd_keys[s*KEY_W +: KEY_W] == key_r);
    end
    free_slots = ~rd_vld;
    first_free = free_slots & (~free_slots + SLOTS'(1));
    placed     = |free_slots;
    wr_keys    = rd_keys;
    for (int s = 0; s < SLOTS; s++) begin
      if (first_free[s]) begin
        wr_keys[s*KEY_W +: KEY_W] = key_r;
      end
    end
    if (cmd_r == CMD_INSERT) begin
      wr_vld = rd_vld | first_free;
    end else begin
      wr_vld = rd_vld & ~hit;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mem_rd_en     = 1'b0;
    mem_wr_en     = 1'b0;
    mem_addr      = (state_r == ST_UPD) ? bucket_r : AW'(div_rem);
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mem_rd_en = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (go) begin
          mem_wr_en = ((cmd_r == CMD_INSERT) && placed) || (cmd_r == CMD_REMOVE);
          out_valid_nxt       = 1'b1;
          out_data_nxt.found  = (cmd_r == CMD_SEARCH) && (|hit);
          out_data_nxt.status = (cmd_r == CMD_INSERT) && !placed;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_xfer) begin
      cmd_r <= in_data.cmd;
      key_r <= in_data.key;
    end
    if (state_r == ST_DIV && div_done) begin
      bucket_r <= AW'(div_rem);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_div_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == ST_DIV))
    else $error("remainder unit running outside the divide phase");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("remainder unit restarted while busy");

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd_en && mem_wr_en))
    else $error("read and write of the bucket ram in one cycle");
`endif

endmodule
